@@ sv/pdce_pkg.sv @@
// Shared types and constants for the pixel depth and channel expander.
package pdce_pkg;

    localparam int NUM_LANES  = 4;
    localparam int SAMPLE_W   = 16;
    localparam int REM_W      = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_IN_BITS      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_BITS     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_CHANNELS  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_CHANNELS = 4'd3;

    localparam logic [1:0] CODE_ZERO = 2'd0;
    localparam logic [1:0] CODE_FULL = 2'd1;
    localparam logic [1:0] CODE_DIV  = 2'd2;

    typedef struct packed {
        logic [15:0] nin;
        logic [15:0] nout;
        logic [14:0] half;
        logic [2:0]  ich;
        logic [2:0]  och;
    } pdce_cfg_t;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [SAMPLE_W-1:0] quo;
        logic [1:0]          code;
    } pdce_lane_t;

    typedef struct packed {
        pdce_lane_t [NUM_LANES-1:0] lane;
        logic                       last;
    } pdce_item_t;

endpackage

@@ sv/pdce_cfg.sv @@
// Configuration registers and the derived scale constants.
module pdce_cfg
    import pdce_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output pdce_cfg_t              cfg
);

    logic [4:0]  in_bits_reg;
    logic [4:0]  out_bits_reg;
    logic [2:0]  in_channels_reg;
    logic [2:0]  out_channels_reg;
    logic [4:0]  ib;
    logic [4:0]  ob;
    logic [16:0] nin_wide;
    logic [16:0] nout_wide;
    logic [15:0] half_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_bits_reg      <= 5'd8;
            out_bits_reg     <= 5'd8;
            in_channels_reg  <= 3'd1;
            out_channels_reg <= 3'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_IN_BITS:      in_bits_reg      <= cfg_wr_data;
                REG_OUT_BITS:     out_bits_reg     <= cfg_wr_data;
                REG_IN_CHANNELS:  in_channels_reg  <= cfg_wr_data[2:0];
                REG_OUT_CHANNELS: out_channels_reg <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ib = (in_bits_reg == 5'd0) ? 5'd1 : (in_bits_reg > 5'd16) ? 5'd16 : in_bits_reg;
        ob = (out_bits_reg == 5'd0) ? 5'd1 : (out_bits_reg > 5'd16) ? 5'd16 : out_bits_reg;
        nin_wide  = (17'd1 << ib) - 17'd1;
        nout_wide = (17'd1 << ob) - 17'd1;
        half_wide = (16'd1 << (ib - 5'd1)) - 16'd1;
        cfg.nin  = nin_wide[15:0];
        cfg.nout = nout_wide[15:0];
        cfg.half = half_wide[14:0];
        cfg.ich  = (in_channels_reg == 3'd0) ? 3'd1 :
                   (in_channels_reg > 3'(LANES)) ? 3'(LANES) : in_channels_reg;
        cfg.och  = (out_channels_reg == 3'd0) ? 3'd1 :
                   (out_channels_reg > 3'(LANES)) ? 3'(LANES) : out_channels_reg;
    end

endmodule

@@ sv/pdce_front.sv @@
// Input stage: channel routing and multiplication by the output full scale.
module pdce_front
    import pdce_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pdce_cfg_t                           cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [NUM_LANES-1:0][SAMPLE_W-1:0]  in_sample,
    input  logic                                in_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pdce_item_t                          out_item
);

    typedef struct packed {
        logic [1:0] code;
        logic [1:0] src;
    } route_t;

    function automatic route_t lane_route(input logic [2:0] k, input logic [2:0] ich,
                                          input logic [2:0] och);
        route_t r;
        logic   alpha;
        r.code = CODE_DIV;
        r.src  = 2'd0;
        alpha  = ((och == 3'd2) || (och == 3'd4)) && (k == och - 3'd1);
        if (k >= och) begin
            r.code = CODE_ZERO;
        end else if (alpha) begin
            if (ich == 3'd2) begin
                r.src = 2'd1;
            end else if (ich == 3'd4) begin
                r.src = 2'd3;
            end else begin
                r.code = CODE_FULL;
            end
        end else if ((ich <= 3'd2) && (och >= 3'd3) && (k < 3'd3)) begin
            r.src = 2'd0;
        end else if (k < ich) begin
            r.src = k[1:0];
        end else begin
            r.code = CODE_FULL;
        end
        return r;
    endfunction

    logic       valid_reg;
    pdce_item_t item_reg;
    pdce_item_t item_next;

    always_comb begin
        route_t              rt;
        logic [SAMPLE_W-1:0] s;
        item_next.last = in_last;
        for (int k = 0; k < NUM_LANES; k++) begin
            rt = lane_route(3'(k), cfg.ich, cfg.och);
            s  = in_sample[rt.src];
            item_next.lane[k].rem  = {16'd0, s} * {16'd0, cfg.nout};
            item_next.lane[k].quo  = '0;
            item_next.lane[k].code = (k < LANES) ? rt.code : CODE_ZERO;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ sv/pdce_round.sv @@
// Rounding offset and quotient overflow check ahead of the divider.
module pdce_round
    import pdce_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pdce_cfg_t  cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  pdce_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output pdce_item_t out_item
);

    logic       valid_reg;
    pdce_item_t item_reg;
    pdce_item_t item_next;

    always_comb begin
        logic [REM_W:0] m;
        logic           ovf;
        item_next.last = in_item.last;
        for (int k = 0; k < NUM_LANES; k++) begin
            m   = {1'b0, in_item.lane[k].rem} + {18'd0, cfg.half};
            ovf = m >= {1'b0, cfg.nin, 16'd0};
            item_next.lane[k].rem  = m[REM_W-1:0];
            item_next.lane[k].quo  = '0;
            item_next.lane[k].code = (in_item.lane[k].code == CODE_DIV && ovf) ?
                                     CODE_FULL : in_item.lane[k].code;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ sv/pdce_div_step.sv @@
// One restoring division step: resolves one quotient bit on every lane.
module pdce_div_step
    import pdce_pkg::*;
#(
    parameter int BIT = 15
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  pdce_cfg_t  cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  pdce_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output pdce_item_t out_item
);

    logic             valid_reg;
    pdce_item_t       item_reg;
    pdce_item_t       item_next;
    logic [REM_W-1:0] divisor;

    assign divisor = {16'd0, cfg.nin} << BIT;

    always_comb begin
        item_next = in_item;
        for (int k = 0; k < NUM_LANES; k++) begin
            if (in_item.lane[k].rem >= divisor) begin
                item_next.lane[k].rem      = in_item.lane[k].rem - divisor;
                item_next.lane[k].quo[BIT] = 1'b1;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ sv/pdce_out.sv @@
// Output stage: clamp to full scale, zero unused lanes, hold the result.
module pdce_out
    import pdce_pkg::*;
(
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pdce_cfg_t                           cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pdce_item_t                          in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [NUM_LANES-1:0][SAMPLE_W-1:0]  out_sample,
    output logic                                out_last
);

    logic                               valid_reg;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] sample_reg;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] sample_next;
    logic                               last_reg;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            case (in_item.lane[k].code)
                CODE_ZERO: sample_next[k] = '0;
                CODE_FULL: sample_next[k] = cfg.nout;
                default:   sample_next[k] = (in_item.lane[k].quo > cfg.nout) ?
                                            cfg.nout : in_item.lane[k].quo;
            endcase
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign out_last   = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sample_reg <= sample_next;
            last_reg   <= in_item.last;
        end
    end

endmodule

@@ sv/pixel_depth_channel_expand.sv @@
// Top level of the pixel depth and channel expander.
//
// Converts one pixel per transaction between gray, gray+alpha, RGB and RGBA
// layouts and rescales each sample from in_bits to out_bits with rounding.
// Input transactions arrive on s_valid/s_ready with four samples and a last
// mark; results leave on m_valid/m_ready with four samples and the same mark.
// Unused output lanes read zero.
// Configuration is written through cfg_wr_en/cfg_wr_index/cfg_wr_data; the
// user must write it while no transaction is in flight, which the block does
// not enforce, as every stage reads the live register values. The pipeline is
// one mapping/multiply stage, one rounding stage, sixteen divider stages
// (one quotient bit each) and the output register.
// Throughput: one pixel per clock while m_ready is held high.
// Each stage holds its own valid bit; a stalled receiver stalls every full
// stage through the ready chain, empty stages keep filling, nothing is lost.
// Reset clears all valid bits and loads the register defaults: 8-bit in and
// out, gray input, RGBA output.
module pixel_depth_channel_expand
    import pdce_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_W-1:0]    s_in_sample_0,
    input  logic [SAMPLE_W-1:0]    s_in_sample_1,
    input  logic [SAMPLE_W-1:0]    s_in_sample_2,
    input  logic [SAMPLE_W-1:0]    s_in_sample_3,
    input  logic                   s_in_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_W-1:0]    m_out_sample_0,
    output logic [SAMPLE_W-1:0]    m_out_sample_1,
    output logic [SAMPLE_W-1:0]    m_out_sample_2,
    output logic [SAMPLE_W-1:0]    m_out_sample_3,
    output logic                   m_out_last
);

    localparam int DIV_STAGES = SAMPLE_W;
    localparam int LINKS      = DIV_STAGES + 2;

    pdce_cfg_t                          cfg;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] in_sample;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] out_sample;
    logic       link_valid [LINKS];
    logic       link_ready [LINKS];
    pdce_item_t link_item  [LINKS];

    assign in_sample = {s_in_sample_3, s_in_sample_2, s_in_sample_1, s_in_sample_0};
    assign m_out_sample_0 = out_sample[0];
    assign m_out_sample_1 = out_sample[1];
    assign m_out_sample_2 = out_sample[2];
    assign m_out_sample_3 = out_sample[3];

    pdce_cfg #(
        .LANES(LANES)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    pdce_front #(
        .LANES(LANES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_sample(in_sample),
        .in_last  (s_in_last),
        .out_valid(link_valid[0]),
        .out_ready(link_ready[0]),
        .out_item (link_item[0])
    );

    pdce_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (link_valid[0]),
        .in_ready (link_ready[0]),
        .in_item  (link_item[0]),
        .out_valid(link_valid[1]),
        .out_ready(link_ready[1]),
        .out_item (link_item[1])
    );

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        pdce_div_step #(
            .BIT(DIV_STAGES - 1 - i)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cfg      (cfg),
            .in_valid (link_valid[i+1]),
            .in_ready (link_ready[i+1]),
            .in_item  (link_item[i+1]),
            .out_valid(link_valid[i+2]),
            .out_ready(link_ready[i+2]),
            .out_item (link_item[i+2])
        );
    end

    pdce_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (link_valid[LINKS-1]),
        .in_ready  (link_ready[LINKS-1]),
        .in_item   (link_item[LINKS-1]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_sample(out_sample),
        .out_last  (m_out_last)
    );

`ifndef SYNTHESIS
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("pipeline empty at output but input stalled");

    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_sample_0 <= cfg.nout) && (m_out_sample_1 <= cfg.nout))
        else $error("sample above output full scale");

    a_unused_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (cfg.och < 3'd4) |-> (m_out_sample_3 == '0))
        else $error("unused output lane not zero");
`endif

endmodule
